// ----- hdl/twq_pkg.sv -----
// shared types, constants and the command decoder for the timed wait queue
// no dependencies; compile first
package twq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned TASK_W   = 8;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned STATUS_W = 3;

  // raw command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_SUSPEND    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WAKE_NAMED = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE_OLD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WAKE_ALL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAKE_UNTIL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POP_NEWEST = 3'd5;

  typedef enum logic [2:0] {
    OP_SUSPEND,
    OP_NAMED,
    OP_OLDEST,
    OP_ALL,
    OP_UNTIL,
    OP_POP,
    OP_NONE
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED   = 3'd0,
    ST_RELEASED = 3'd1,
    ST_POPPED   = 3'd2,
    ST_NOTHING  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUSP,
    S_SWEEP,
    S_POP_RD,
    S_POP_EMIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] wake_time;
    logic [TIME_W-1:0] current_time;
  } cmd_t;

  function automatic op_t classify(input logic [CMD_W-1:0] command);
    op_t op;
    unique case (command)
      CMD_SUSPEND:    op = OP_SUSPEND;
      CMD_WAKE_NAMED: op = OP_NAMED;
      CMD_WAKE_OLD:   op = OP_OLDEST;
      CMD_WAKE_ALL:   op = OP_ALL;
      CMD_WAKE_UNTIL: op = OP_UNTIL;
      CMD_POP_NEWEST: op = OP_POP;
      default:        op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

// ----- hdl/twq_in_if.sv -----
// command channel interface: valid/ready plus the command beat fields
// depends on twq_pkg for field widths
interface twq_in_if;
  logic                        valid;
  logic                        ready;
  logic [twq_pkg::CMD_W-1:0]   command;
  logic [twq_pkg::TASK_W-1:0]  task_id;
  logic [twq_pkg::TIME_W-1:0]  wake_time;
  logic [twq_pkg::TIME_W-1:0]  current_time;

  modport source (output valid, command, task_id, wake_time, current_time, input ready);
  modport sink   (input valid, command, task_id, wake_time, current_time, output ready);
endinterface

// ----- hdl/twq_out_if.sv -----
// result channel interface: valid/ready plus the result beat fields
// depends on twq_pkg for field widths
interface twq_out_if;
  logic                          valid;
  logic                          ready;
  logic [twq_pkg::TASK_W-1:0]    out_task;
  logic [twq_pkg::STATUS_W-1:0]  status;
  logic                          last;

  modport source (output valid, out_task, status, last, input ready);
  modport sink   (input valid, out_task, status, last, output ready);
endinterface

// ----- hdl/twq_front.sv -----
// front end: accepts command beats, decodes them and buffers them in a
// two-entry queue toward the back end; depends on twq_pkg and twq_in_if
module twq_front (
  input  logic           clk,
  input  logic           rst_n,
  twq_in_if.sink         in_ch,
  output twq_pkg::cmd_t  cmd_data,
  output logic           cmd_valid,
  input  logic           cmd_ready
);
  import twq_pkg::*;

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       decoded;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd_data    = fifo_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = cmd_valid && cmd_ready;

  always_comb begin
    decoded.op           = classify(in_ch.command);
    decoded.task_id      = in_ch.task_id;
    decoded.wake_time    = in_ch.wake_time;
    decoded.current_time = in_ch.current_time;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= decoded;
    end
  end

endmodule

// ----- hdl/twq_back.sv -----
// back end: holds the task/deadline memory and executes one command at a
// time, sweeping entries one per cycle unless out_ch stalls; depends on twq_pkg and twq_out_if
module twq_back #(
  parameter int unsigned QUEUE_DEPTH = twq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  twq_pkg::cmd_t  cmd_in,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  twq_out_if.source      out_ch
);
  import twq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IW = $clog2(QUEUE_DEPTH);

  logic [TASK_W-1:0] task_mem [QUEUE_DEPTH];
  logic [TIME_W-1:0] dl_mem   [QUEUE_DEPTH];

  state_t            state_r, state_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]     kept_r, kept_nxt;
  logic              proc_valid_r, proc_valid_nxt;
  logic              first_r, first_nxt;
  logic              found_r, found_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [TASK_W-1:0] pend_task_r, pend_task_nxt;
  logic [TASK_W-1:0] rd_task_r;
  logic [TIME_W-1:0] rd_dl_r;
  logic              out_valid_r, out_valid_nxt;
  logic [TASK_W-1:0] out_task_r, out_task_nxt;
  status_t           status_r, status_nxt;
  logic              last_r, last_nxt;

  logic              can_emit, sweep_done, rel;
  logic              mem_we, rd_en;
  logic [IW-1:0]     waddr, rd_addr;
  logic [TASK_W-1:0] wtask;
  logic [TIME_W-1:0] wdl;
  logic              emit, emit_last;
  logic [TASK_W-1:0] emit_task;
  status_t           emit_status;
  logic [CW-1:0]     occ_dec;

  assign can_emit   = !out_valid_r || out_ch.ready;
  assign sweep_done = !proc_valid_r && (rd_idx_r == occ_r);
  assign occ_dec    = occ_r - 1'b1;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_task = out_task_r;
  assign out_ch.status   = status_r;
  assign out_ch.last     = last_r;

  always_comb begin
    unique case (cmd_r.op)
      OP_NAMED:  rel = !found_r && (rd_task_r == cmd_r.task_id);
      OP_OLDEST: rel = first_r;
      OP_ALL:    rel = 1'b1;
      OP_UNTIL:  rel = (rd_dl_r <= cmd_r.current_time);
      default:   rel = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_in.op)
            OP_SUSPEND: state_nxt = S_SUSP;
            OP_POP:     state_nxt = S_POP_RD;
            OP_NONE:    state_nxt = S_FINISH;
            default:    state_nxt = S_SWEEP;
          endcase
        end
      end
      S_SUSP:     if (can_emit) state_nxt = S_IDLE;
      S_SWEEP:    if (can_emit && sweep_done) state_nxt = S_FINISH;
      S_POP_RD:   state_nxt = (occ_r == '0) ? S_FINISH : S_POP_EMIT;
      S_POP_EMIT: if (can_emit) state_nxt = S_IDLE;
      S_FINISH:   if (can_emit) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    occ_nxt        = occ_r;
    cmd_nxt        = cmd_r;
    rd_idx_nxt     = rd_idx_r;
    kept_nxt       = kept_r;
    proc_valid_nxt = proc_valid_r;
    first_nxt      = first_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_task_nxt  = pend_task_r;
    cmd_ready      = 1'b0;
    mem_we         = 1'b0;
    waddr          = '0;
    wtask          = rd_task_r;
    wdl            = rd_dl_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    emit           = 1'b0;
    emit_task      = '0;
    emit_status    = ST_NOTHING;
    emit_last      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt        = cmd_in;
          rd_idx_nxt     = '0;
          proc_valid_nxt = 1'b0;
          found_nxt      = 1'b0;
          pend_valid_nxt = 1'b0;
          kept_nxt       = (cmd_in.op == OP_NONE) ? occ_r : '0;
        end
      end
      S_SUSP: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_task = cmd_r.task_id;
          if (occ_r == CW'(QUEUE_DEPTH)) begin
            emit_status = ST_FULL;
          end else begin
            emit_status = ST_QUEUED;
            mem_we      = 1'b1;
            waddr       = occ_r[IW-1:0];
            wtask       = cmd_r.task_id;
            wdl         = cmd_r.wake_time;
            occ_nxt     = occ_r + 1'b1;
          end
        end
      end
      S_SWEEP: begin
        if (can_emit) begin
          if (proc_valid_r) begin
            if (rel) begin
              // hold the release back one step so the final one gets last
              if (pend_valid_r) begin
                emit        = 1'b1;
                emit_task   = pend_task_r;
                emit_status = ST_RELEASED;
                emit_last   = 1'b0;
              end
              pend_task_nxt  = rd_task_r;
              pend_valid_nxt = 1'b1;
              found_nxt      = 1'b1;
            end else begin
              mem_we   = 1'b1;
              waddr    = kept_r[IW-1:0];
              kept_nxt = kept_r + 1'b1;
            end
          end
          if (rd_idx_r < occ_r) begin
            rd_en          = 1'b1;
            rd_addr        = rd_idx_r[IW-1:0];
            rd_idx_nxt     = rd_idx_r + 1'b1;
            proc_valid_nxt = 1'b1;
            first_nxt      = (rd_idx_r == '0);
          end else begin
            proc_valid_nxt = 1'b0;
          end
        end
      end
      S_POP_RD: begin
        if (occ_r != '0) begin
          rd_en   = 1'b1;
          rd_addr = occ_dec[IW-1:0];
          occ_nxt = occ_dec;
        end
      end
      S_POP_EMIT: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_task   = rd_task_r;
          emit_status = ST_POPPED;
        end
      end
      S_FINISH: begin
        if (can_emit) begin
          emit    = 1'b1;
          occ_nxt = kept_r;
          if (pend_valid_r) begin
            emit_task   = pend_task_r;
            emit_status = ST_RELEASED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_task_nxt  = out_task_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_task_nxt  = emit_task;
      status_nxt    = emit_status;
      last_nxt      = emit_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      proc_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      proc_valid_r <= proc_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    rd_idx_r     <= rd_idx_nxt;
    kept_r       <= kept_nxt;
    first_r      <= first_nxt;
    found_r      <= found_nxt;
    pend_valid_r <= pend_valid_nxt;
    pend_task_r  <= pend_task_nxt;
    out_task_r   <= out_task_nxt;
    status_r     <= status_nxt;
    last_r       <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      task_mem[waddr] <= wtask;
      dl_mem[waddr]   <= wdl;
    end
    if (rd_en) begin
      rd_task_r <= task_mem[rd_addr];
      rd_dl_r   <= dl_mem[rd_addr];
    end
  end

endmodule

// ----- hdl/timed_wait_queue.sv -----
// timed wait queue top level: command front end, command queue and sweeping
// back end; depends on twq_pkg, twq_in_if, twq_out_if, twq_front, twq_back
//
// in_ch carries one command beat per handshake (valid & ready): suspend,
// wake named, wake oldest, wake all, wake until time, pop newest.
// out_ch carries result beats: released/removed task id, status and last.
// Every command yields at least one result beat; the last beat of a command
// has last set. Released tasks come out oldest first.
// A two-entry command queue sits in front, so commands are taken while the
// back end is busy or while a result waits at out_ch.
// The wake commands sweep the occupied entries through the single memory
// read port, one entry a cycle while out_ch does not stall the back end;
// the back end takes the next command from the queue only once the last
// result beat of the current one is in the output register.
// A result sits in an output register until out_ch.ready; while it waits
// the back end holds, and the command queue fills and then drops in ready.
// Reset empties the queue and the command buffer; stored entries are not
// cleared since only slots below the occupancy are ever read.
module timed_wait_queue #(
  parameter int unsigned QUEUE_DEPTH = twq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  twq_in_if.sink   in_ch,
  twq_out_if.source out_ch
);
  import twq_pkg::*;

  // decoded command handoff between front and back
  cmd_t cmd_data;
  logic cmd_valid;
  logic cmd_ready;

  twq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_data  (cmd_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  twq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_in    (cmd_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch)
  );

endmodule
